// ----- sv/pfa_pkg.sv -----
package pfa_pkg;

  // Default table sizes.
  localparam int VIRT_PAGES_DEF  = 4096;
  localparam int FRAME_SLOTS_DEF = 4096;

  // Field widths fixed by the command format.
  localparam int OP_W     = 3;
  localparam int ADDR_W   = 32;
  localparam int COUNT_W  = 13;
  localparam int STATUS_W = 3;
  localparam int FRAME_W  = 20;
  localparam int ENTRY_W  = FRAME_W + 1;
  localparam int PAGE_SH  = 12;

  // Command codes.
  localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
  localparam logic [OP_W-1:0] OP_MAP     = 3'd1;
  localparam logic [OP_W-1:0] OP_UNMAP   = 3'd2;
  localparam logic [OP_W-1:0] OP_ALLOC   = 3'd3;
  localparam logic [OP_W-1:0] OP_DEALLOC = 3'd4;
  localparam logic [OP_W-1:0] OP_READ    = 3'd5;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISALIGNED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FEW        = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NORUN      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd5;

  localparam logic [ADDR_W-1:0] ENTRY_FLAGS = 32'h0000_0003;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_SCAN,
    S_ALLOC,
    S_DEALLOC,
    S_RESP
  } state_t;

endpackage

// ----- sv/pfa_if.sv -----
interface pfa_in_if;
  import pfa_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [ADDR_W-1:0]   virt_addr;
  logic [ADDR_W-1:0]   frame_addr;
  logic [COUNT_W-1:0]  page_count;
  modport source (output valid, op, virt_addr, frame_addr, page_count, input ready);
  modport sink   (input valid, op, virt_addr, frame_addr, page_count, output ready);
endinterface

interface pfa_out_if;
  import pfa_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   result_addr;
  logic [COUNT_W-1:0]  free_frames;
  modport source (output valid, status, result_addr, free_frames, input ready);
  modport sink   (input valid, status, result_addr, free_frames, output ready);
endinterface

// ----- sv/page_frame_allocator.sv -----
// Page frame allocator. Each input item is one command (push a free frame, map,
// unmap, alloc, dealloc, read an entry) and gives exactly one result item. The
// entry table and the free frame stack each live in a single-port-read,
// single-port-write synchronous memory. After reset the block sweeps the entry
// table clear, one entry a cycle, before it accepts the first item. Alloc
// scans the table one entry a cycle from entry 0 until it finds the run, then
// pops and maps one page a cycle. Dealloc moves one page a cycle. The memory
// read port, one access per cycle, sets these rates. The next item is accepted
// while a finished result still waits on the output.
module page_frame_allocator #(
  parameter int VIRT_PAGES  = pfa_pkg::VIRT_PAGES_DEF,
  parameter int FRAME_SLOTS = pfa_pkg::FRAME_SLOTS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  pfa_in_if.sink    in_ch,
  pfa_out_if.source out_ch
);
  import pfa_pkg::*;

  localparam int VPW = (VIRT_PAGES > 1) ? $clog2(VIRT_PAGES) : 1;
  localparam int SW  = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int CW  = $clog2(FRAME_SLOTS + 1);

  // Memories.
  logic [ENTRY_W-1:0] page_mem [VIRT_PAGES];
  logic [FRAME_W-1:0] stack_mem [FRAME_SLOTS];

  state_t state_r, state_nxt;

  logic [OP_W-1:0]     op_r;
  logic [ADDR_W-1:0]   va_r, fa_r;
  logic [COUNT_W-1:0]  cnt_r;
  logic [CW-1:0]       top_r, top_nxt;
  logic [VPW:0]        scan_r, scan_nxt;
  logic [COUNT_W-1:0]  run_r, run_nxt;
  logic [COUNT_W-1:0]  iss_r, iss_nxt;
  logic [VPW-1:0]      start_r, start_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [VPW-1:0]      rd_idx_r, rd_idx_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [ADDR_W-1:0]   res_r, res_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic [COUNT_W-1:0]  out_free_r;
  logic                out_load;

  // Memory port controls.
  logic               pg_we, pg_re;
  logic [VPW-1:0]     pg_waddr, pg_raddr;
  logic [ENTRY_W-1:0] pg_wdata, pg_rdata_r;
  logic               st_we, st_re;
  logic [SW-1:0]      st_waddr, st_raddr;
  logic [FRAME_W-1:0] st_wdata, st_rdata_r;

  // Decoded command fields.
  logic               va_bad, fa_bad;
  logic [19:0]        vpage;
  logic [FRAME_W-1:0] fnum;
  logic               vp_out;
  logic [31:0]        top32, cnt32, vp32, iss32;

  assign va_bad = |va_r[PAGE_SH-1:0];
  assign fa_bad = |fa_r[PAGE_SH-1:0];
  assign vpage  = va_r[ADDR_W-1:PAGE_SH];
  assign fnum   = fa_r[ADDR_W-1:PAGE_SH];
  assign top32  = 32'(top_r);
  assign cnt32  = 32'(cnt_r);
  assign vp32   = 32'(vpage);
  assign iss32  = 32'(iss_r);
  assign vp_out = vp32 >= 32'(VIRT_PAGES);

  // Entry table memory.
  always_ff @(posedge clk) begin
    if (pg_we) begin
      page_mem[pg_waddr] <= pg_wdata;
    end
    if (pg_re) begin
      pg_rdata_r <= page_mem[pg_raddr];
    end
  end

  // Free frame stack memory.
  always_ff @(posedge clk) begin
    if (st_we) begin
      stack_mem[st_waddr] <= st_wdata;
    end
    if (st_re) begin
      st_rdata_r <= stack_mem[st_raddr];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      top_r       <= '0;
      scan_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      scan_r      <= scan_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Command and working registers.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid) begin
      op_r  <= in_ch.op;
      va_r  <= in_ch.virt_addr;
      fa_r  <= in_ch.frame_addr;
      cnt_r <= in_ch.page_count;
    end
    run_r    <= run_nxt;
    iss_r    <= iss_nxt;
    start_r  <= start_nxt;
    rd_idx_r <= rd_idx_nxt;
    status_r <= status_nxt;
    res_r    <= res_nxt;
    if (out_load) begin
      out_status_r <= status_r;
      out_addr_r   <= res_r;
      out_free_r   <= COUNT_W'(top_r);
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.result_addr = out_addr_r;
  assign out_ch.free_frames = out_free_r;

  // Next state, memory accesses and working values.
  always_comb begin
    state_nxt  = state_r;
    top_nxt    = top_r;
    scan_nxt   = scan_r;
    run_nxt    = run_r;
    iss_nxt    = iss_r;
    start_nxt  = start_r;
    rd_vld_nxt = rd_vld_r;
    rd_idx_nxt = rd_idx_r;
    status_nxt = status_r;
    res_nxt    = res_r;
    out_load   = 1'b0;
    pg_we      = 1'b0;
    pg_waddr   = vpage[VPW-1:0];
    pg_wdata   = '0;
    pg_re      = 1'b0;
    pg_raddr   = vpage[VPW-1:0];
    st_we      = 1'b0;
    st_waddr   = top_r[SW-1:0];
    st_wdata   = fnum;
    st_re      = 1'b0;
    st_raddr   = SW'(top_r - CW'(1));

    unique case (state_r)
      S_CLEAR: begin
        pg_we    = 1'b1;
        pg_waddr = scan_r[VPW-1:0];
        scan_nxt = scan_r + 1'b1;
        if (32'(scan_r) == 32'(VIRT_PAGES - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        status_nxt = ST_OK;
        res_nxt    = '0;
        state_nxt  = S_RESP;
        iss_nxt    = '0;
        rd_vld_nxt = 1'b0;
        unique case (op_r)
          OP_PUSH: begin
            if (fa_bad) begin
              status_nxt = ST_MISALIGNED;
            end else if (top32 >= 32'(FRAME_SLOTS)) begin
              status_nxt = ST_FULL;
            end else begin
              st_we   = 1'b1;
              top_nxt = top_r + 1'b1;
            end
          end
          OP_MAP, OP_UNMAP: begin
            if (va_bad || (op_r == OP_MAP && fa_bad)) begin
              status_nxt = ST_MISALIGNED;
            end else if (vp_out) begin
              status_nxt = ST_RANGE;
            end else begin
              pg_we    = 1'b1;
              pg_wdata = (op_r == OP_MAP) ? {1'b1, fnum} : '0;
            end
          end
          OP_ALLOC: begin
            if (cnt_r == '0) begin
              status_nxt = ST_RANGE;
            end else if (top32 < cnt32) begin
              status_nxt = ST_FEW;
            end else begin
              scan_nxt  = '0;
              run_nxt   = '0;
              state_nxt = S_SCAN;
            end
          end
          OP_DEALLOC: begin
            if (va_bad) begin
              status_nxt = ST_MISALIGNED;
            end else if (cnt_r == '0 || vp_out || cnt32 > 32'(VIRT_PAGES) - vp32) begin
              status_nxt = ST_RANGE;
            end else if (cnt32 > 32'(FRAME_SLOTS) - top32) begin
              status_nxt = ST_FULL;
            end else begin
              state_nxt = S_DEALLOC;
            end
          end
          OP_READ: begin
            if (va_bad) begin
              status_nxt = ST_MISALIGNED;
            end else if (vp_out) begin
              status_nxt = ST_RANGE;
            end else begin
              pg_re     = 1'b1;
              state_nxt = S_RDWAIT;
            end
          end
          default: begin
            status_nxt = ST_RANGE;
          end
        endcase
      end

      S_RDWAIT: begin
        if (pg_rdata_r[ENTRY_W-1]) begin
          res_nxt = {pg_rdata_r[FRAME_W-1:0], 12'h000} | ENTRY_FLAGS;
        end
        state_nxt = S_RESP;
      end

      // One entry read a cycle; the entry read last cycle is evaluated here.
      S_SCAN: begin
        if (rd_vld_r && !pg_rdata_r[ENTRY_W-1] && (run_r + 1'b1) >= cnt_r) begin
          if (run_r == '0) begin
            start_nxt = rd_idx_r;
          end
          rd_vld_nxt = 1'b0;
          iss_nxt    = '0;
          state_nxt  = S_ALLOC;
        end else begin
          if (rd_vld_r) begin
            if (pg_rdata_r[ENTRY_W-1]) begin
              run_nxt = '0;
            end else begin
              if (run_r == '0) begin
                start_nxt = rd_idx_r;
              end
              run_nxt = run_r + 1'b1;
            end
          end
          if (32'(scan_r) < 32'(VIRT_PAGES)) begin
            pg_re      = 1'b1;
            pg_raddr   = scan_r[VPW-1:0];
            rd_vld_nxt = 1'b1;
            rd_idx_nxt = scan_r[VPW-1:0];
            scan_nxt   = scan_r + 1'b1;
          end else begin
            rd_vld_nxt = 1'b0;
            if (!rd_vld_r) begin
              status_nxt = ST_NORUN;
              state_nxt  = S_RESP;
            end
          end
        end
      end

      // Pop one frame a cycle and map it on the following cycle.
      S_ALLOC: begin
        if (rd_vld_r) begin
          pg_we    = 1'b1;
          pg_waddr = rd_idx_r;
          pg_wdata = {1'b1, st_rdata_r};
        end
        if (iss_r < cnt_r) begin
          st_re      = 1'b1;
          top_nxt    = top_r - 1'b1;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = VPW'(32'(start_r) + iss32);
          iss_nxt    = iss_r + 1'b1;
        end else begin
          rd_vld_nxt = 1'b0;
          if (!rd_vld_r) begin
            res_nxt   = 32'(start_r) << PAGE_SH;
            state_nxt = S_RESP;
          end
        end
      end

      // Read one entry a cycle; push its frame and clear it on the next.
      S_DEALLOC: begin
        if (rd_vld_r) begin
          st_we    = 1'b1;
          st_wdata = pg_rdata_r[FRAME_W-1:0];
          top_nxt  = top_r + 1'b1;
          pg_we    = 1'b1;
          pg_waddr = rd_idx_r;
          pg_wdata = '0;
        end
        if (iss_r < cnt_r) begin
          pg_re      = 1'b1;
          pg_raddr   = VPW'(vp32 + iss32);
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = VPW'(vp32 + iss32);
          iss_nxt    = iss_r + 1'b1;
        end else begin
          rd_vld_nxt = 1'b0;
          if (!rd_vld_r) begin
            state_nxt = S_RESP;
          end
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register handshake.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

endmodule

// ----- test/tb_page_frame_allocator.sv -----
module tb_page_frame_allocator;
  import pfa_pkg::*;

  localparam int VPAGES     = VIRT_PAGES_DEF;
  localparam int SLOTS      = FRAME_SLOTS_DEF;
  localparam int IDLE_LIMIT = 60000;

  // Command codes that the block does not define.
  localparam logic [OP_W-1:0] OP_UNDEF_A = 3'd6;
  localparam logic [OP_W-1:0] OP_UNDEF_B = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   addr;
    logic [COUNT_W-1:0]  free;
  } cmd_result_t;

  logic clk;
  logic rst_n;

  pfa_in_if  in_ch ();
  pfa_out_if out_ch ();

  page_frame_allocator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Shadow copy of the entry table and the free frame stack.
  logic [ENTRY_W-1:0] shadow_entries [VPAGES];
  logic [FRAME_W-1:0] shadow_stack [SLOTS];
  int unsigned        shadow_top;

  cmd_result_t expected_results [$];
  int errors;
  int items_sent;
  int results_checked;
  int allocs_mapped;
  int idle_pct;
  int stall_pct;
  int quiet_cycles;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random back-pressure at the current stall rate.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                 input logic [ADDR_W-1:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
    errors++;
  endtask

  // Computes the result of one command and updates the shadow state.
  function automatic cmd_result_t predict_command(input logic [OP_W-1:0] op,
                                                  input logic [ADDR_W-1:0] va,
                                                  input logic [ADDR_W-1:0] fa,
                                                  input logic [COUNT_W-1:0] cnt);
    cmd_result_t r;
    int unsigned vpage;
    logic [FRAME_W-1:0] fnum;
    bit va_bad;
    bit fa_bad;
    bit found;
    int unsigned run;
    int unsigned start;
    r = '0;
    r.status = ST_OK;
    vpage = va >> PAGE_SH;
    fnum = fa[ADDR_W-1:PAGE_SH];
    va_bad = (va[PAGE_SH-1:0] != '0);
    fa_bad = (fa[PAGE_SH-1:0] != '0);
    found = 1'b0;
    run = 0;
    start = 0;
    case (op)
      OP_PUSH: begin
        if (fa_bad) r.status = ST_MISALIGNED;
        else if (shadow_top >= SLOTS) r.status = ST_FULL;
        else begin
          shadow_stack[shadow_top] = fnum;
          shadow_top++;
        end
      end
      OP_MAP: begin
        if (va_bad || fa_bad) r.status = ST_MISALIGNED;
        else if (vpage >= VPAGES) r.status = ST_RANGE;
        else shadow_entries[vpage] = {1'b1, fnum};
      end
      OP_UNMAP: begin
        if (va_bad) r.status = ST_MISALIGNED;
        else if (vpage >= VPAGES) r.status = ST_RANGE;
        else shadow_entries[vpage] = '0;
      end
      OP_ALLOC: begin
        if (cnt == 0) r.status = ST_RANGE;
        else if (shadow_top < cnt) r.status = ST_FEW;
        else begin
          // First run of non-present entries that is long enough.
          for (int i = 0; i < VPAGES && !found; i++) begin
            if (shadow_entries[i][FRAME_W]) run = 0;
            else begin
              if (run == 0) start = i;
              run++;
              if (run >= cnt) found = 1'b1;
            end
          end
          if (!found) r.status = ST_NORUN;
          else begin
            for (int i = 0; i < cnt; i++) begin
              shadow_top--;
              shadow_entries[start + i] = {1'b1, shadow_stack[shadow_top]};
            end
            r.addr = start << PAGE_SH;
            allocs_mapped++;
          end
        end
      end
      OP_DEALLOC: begin
        if (va_bad) r.status = ST_MISALIGNED;
        else if (cnt == 0 || vpage >= VPAGES || cnt > VPAGES - vpage) r.status = ST_RANGE;
        else if (cnt > SLOTS - shadow_top) r.status = ST_FULL;
        else begin
          // Every entry goes back on the stack, present or not.
          for (int i = 0; i < cnt; i++) begin
            shadow_stack[shadow_top] = shadow_entries[vpage + i][FRAME_W-1:0];
            shadow_top++;
            shadow_entries[vpage + i] = '0;
          end
        end
      end
      OP_READ: begin
        if (va_bad) r.status = ST_MISALIGNED;
        else if (vpage >= VPAGES) r.status = ST_RANGE;
        else if (shadow_entries[vpage][FRAME_W])
          r.addr = {shadow_entries[vpage][FRAME_W-1:0], 12'h000} | ENTRY_FLAGS;
      end
      default: r.status = ST_RANGE;
    endcase
    r.free = shadow_top[COUNT_W-1:0];
    return r;
  endfunction

  // Sends one item; the expectation is recorded when the item is accepted.
  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] va,
                          input logic [ADDR_W-1:0] fa, input logic [COUNT_W-1:0] cnt);
    if ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.virt_addr  <= va;
    in_ch.frame_addr <= fa;
    in_ch.page_count <= cnt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_results.push_back(predict_command(op, va, fa, cnt));
    items_sent++;
  endtask

  // Holds the sender off until every expected result has arrived.
  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Result checker.
  always @(posedge clk) begin
    cmd_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result item", out_ch.result_addr, '0);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_ch.status !== want.status)
          report_mismatch("status", 32'(out_ch.status), 32'(want.status));
        if (out_ch.result_addr !== want.addr)
          report_mismatch("result_addr", out_ch.result_addr, want.addr);
        if (out_ch.free_frames !== want.free)
          report_mismatch("free_frames", 32'(out_ch.free_frames), 32'(want.free));
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("tb_page_frame_allocator: FAIL");
      $finish;
    end
  end

  function automatic logic [ADDR_W-1:0] pick_vaddr();
    int r;
    r = $urandom_range(99);
    if (r < 60) return {20'($urandom_range(63)), 12'h000};
    if (r < 80) return {20'($urandom_range(VPAGES - 1)), 12'h000};
    if (r < 90) return $urandom & 32'hFFFF_F000;
    return $urandom;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_frame();
    if ($urandom_range(9) == 0) return $urandom;
    return $urandom & 32'hFFFF_F000;
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 80) return 13'($urandom_range(8, 1));
    if (r < 90) return 13'($urandom_range(64, 9));
    if (r < 95) return '0;
    return 13'($urandom_range(VPAGES));
  endfunction

  // Single commands and their error cases on a fresh table.
  task automatic test_single_ops();
    send_cmd(OP_READ, 32'h0, 32'h0, '0);
    send_cmd(OP_PUSH, 32'h0, 32'h0000_0001, '0);
    send_cmd(OP_PUSH, 32'h0, 32'hFFFF_F000, '0);
    send_cmd(OP_MAP, 32'hFFFF_F000, 32'h0000_1000, '0);
    send_cmd(OP_MAP, 32'h00FF_F000, 32'h1234_5000, '0);
    send_cmd(OP_READ, 32'h00FF_F000, 32'h0, '0);
    send_cmd(OP_MAP, 32'h0000_0800, 32'h0000_1000, '0);
    send_cmd(OP_UNMAP, 32'h00FF_F000, 32'h0, '0);
    send_cmd(OP_READ, 32'h00FF_F000, 32'h0, '0);
    send_cmd(OP_UNMAP, 32'h0000_0FFF, 32'h0, '0);
    send_cmd(OP_UNMAP, 32'h0100_0000, 32'h0, '0);
    send_cmd(OP_READ, 32'hFFFF_FFFF, 32'h0, '0);
    send_cmd(OP_UNDEF_A, 32'h0, 32'h0, '0);
    send_cmd(OP_UNDEF_B, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 13'h1FFF);
  endtask

  // Zero counts, too few frames, full stack and no free run.
  task automatic test_alloc_dealloc_limits();
    send_cmd(OP_ALLOC, 32'h0, 32'h0, '0);
    send_cmd(OP_ALLOC, 32'h0, 32'h0, 13'd2);
    send_cmd(OP_ALLOC, 32'h0, 32'h0, 13'd1);
    send_cmd(OP_READ, 32'h0, 32'h0, '0);
    send_cmd(OP_DEALLOC, 32'h0, 32'h0, '0);
    send_cmd(OP_DEALLOC, 32'h00FF_F000, 32'h0, 13'd2);
    send_cmd(OP_DEALLOC, 32'h0000_0010, 32'h0, 13'd1);
    send_cmd(OP_DEALLOC, 32'h0, 32'h0, 13'd4096);
    send_cmd(OP_PUSH, 32'h0, 32'h0000_5000, '0);
    send_cmd(OP_DEALLOC, 32'h0, 32'h0, 13'd1);
    send_cmd(OP_ALLOC, 32'h0, 32'h0, 13'd4096);
    send_cmd(OP_ALLOC, 32'h0, 32'h0, 13'd1);
    send_cmd(OP_PUSH, 32'h0, 32'h0000_0000, '0);
    send_cmd(OP_ALLOC, 32'h0, 32'h0, 13'd1);
    // Leave most low pages free and the stack well filled.
    send_cmd(OP_DEALLOC, 32'h0, 32'h0, 13'd4095);
    send_cmd(OP_ALLOC, 32'h0, 32'h0, 13'd4000);
    send_cmd(OP_DEALLOC, 32'h0, 32'h0, 13'd3900);
  endtask

  // Random command mix at the given idle and stall rates.
  task automatic test_random_traffic(input int n, input int in_idle, input int out_stall);
    int r;
    idle_pct = in_idle;
    stall_pct = out_stall;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 20) send_cmd(OP_PUSH, $urandom, pick_frame(), 13'($urandom));
      else if (r < 35) send_cmd(OP_MAP, pick_vaddr(), pick_frame(), 13'($urandom));
      else if (r < 45) send_cmd(OP_UNMAP, pick_vaddr(), $urandom, 13'($urandom));
      else if (r < 62) send_cmd(OP_ALLOC, $urandom, $urandom, pick_count());
      else if (r < 77) send_cmd(OP_DEALLOC, pick_vaddr(), $urandom, pick_count());
      else if (r < 97) send_cmd(OP_READ, pick_vaddr(), $urandom, 13'($urandom));
      else if (r < 98) send_cmd(OP_UNDEF_A, $urandom, $urandom, 13'($urandom));
      else send_cmd(OP_UNDEF_B, $urandom, $urandom, 13'($urandom));
    end
  endtask

  initial begin
    errors = 0;
    items_sent = 0;
    results_checked = 0;
    allocs_mapped = 0;
    idle_pct = 0;
    stall_pct = 0;
    quiet_cycles = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_READ;
    in_ch.virt_addr = '0;
    in_ch.frame_addr = '0;
    in_ch.page_count = '0;
    out_ch.ready = 1'b0;
    foreach (shadow_entries[i]) shadow_entries[i] = '0;
    foreach (shadow_stack[i]) shadow_stack[i] = '0;
    shadow_top = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_single_ops();
    test_alloc_dealloc_limits();
    wait_all_results();
    test_random_traffic(400, 0, 0);
    test_random_traffic(400, 63, 0);
    wait_all_results();
    test_random_traffic(400, 0, 63);
    test_random_traffic(420, 13, 13);

    // Drain and let the block settle.
    wait_all_results();
    repeat (50) @(posedge clk);

    $display("Sent %0d commands, checked %0d results, %0d successful allocs.",
             items_sent, results_checked, allocs_mapped);
    $display("Covered error codes, table and stack extremes and four idle/stall mixes.");
    if (errors == 0) begin
      $display("tb_page_frame_allocator: PASS");
    end else begin
      $display("tb_page_frame_allocator: FAIL");
    end
    $finish;
  end

endmodule
